FILE: design/oepr_pkg.sv
// Shared types, constants and the ring trig table for the oriented ellipse point ring.
// No dependencies; every module in the project imports this package.
package oepr_pkg;

  localparam int RING_POINTS  = 10;
  localparam int PNT_W        = $clog2(RING_POINTS);
  localparam int CORDIC_STEPS = 16;
  localparam int ONE_Q14      = 16384;
  localparam int REG_W        = 18;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [1:0] REG_ALONG  = 2'd0;
  localparam logic [1:0] REG_ACROSS = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  localparam logic [REG_W-1:0] ALONG_RESET  = 18'd9830;
  localparam logic [REG_W-1:0] ACROSS_RESET = 18'd13107;
  localparam logic [REG_W-1:0] OFFSET_RESET = 18'd3277;

  localparam longint Q28_HALF_PI     = 64'sd421657428;
  localparam longint Q28_PI          = 64'sd843314857;
  localparam longint Q28_TWO_PI      = 64'sd1686629713;
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic               final_p;
  } pose_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] c;
    logic signed [15:0] s;
    logic               final_p;
  } head_t;

  typedef logic [RING_POINTS-1:0][31:0] ring_tab_t;

  function automatic longint clamp_one(longint v);
    longint r;
    r = v;
    if (v > ONE_Q14) r = ONE_Q14;
    if (v < -ONE_Q14) r = -ONE_Q14;
    return r;
  endfunction

  function automatic ring_tab_t ring_table();
    ring_tab_t tab;
    longint atan_q28 [CORDIC_STEPS];
    longint m, mag, th, x, y, nx, rc, rs;
    logic flip;
    atan_q28 = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
                 16384, 8192};
    for (int j = 0; j < RING_POINTS; j++) begin
      m = (2 * (j + 1) <= RING_POINTS) ? j + 1 : j + 1 - RING_POINTS;
      mag = (m < 0) ? -m : m;
      th = (mag * Q28_TWO_PI + RING_POINTS / 2) / RING_POINTS;
      if (m < 0) th = -th;
      flip = 1'b0;
      if (th > Q28_HALF_PI) begin
        th = th - Q28_PI;
        flip = 1'b1;
      end else if (th < -Q28_HALF_PI) begin
        th = th + Q28_PI;
        flip = 1'b1;
      end
      x = CORDIC_GAIN_Q30;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (th >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          th = th - atan_q28[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          th = th + atan_q28[i];
        end
        x = nx;
      end
      rc = clamp_one((x + 32768) >>> 16);
      rs = clamp_one((y + 32768) >>> 16);
      if (flip) begin
        rc = -rc;
        rs = -rs;
      end
      tab[j] = {rc[15:0], rs[15:0]};
    end
    return tab;
  endfunction

  localparam ring_tab_t RING_TAB = ring_table();

endpackage

FILE: design/oepr_pose_if.sv
// Input channel of the point ring: one person pose per item.
// No dependencies.
interface oepr_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] person_x;
  logic signed [31:0] person_y;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic               final_person;

  modport source (output valid, person_x, person_y, quat_x, quat_y, quat_z, quat_w,
                  final_person, input ready);
  modport sink (input valid, person_x, person_y, quat_x, quat_y, quat_z, quat_w,
                final_person, output ready);
endinterface

FILE: design/oepr_point_if.sv
// Output channel of the point ring: one ring point per item.
// No dependencies.
interface oepr_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [5:0]         point_number;
  logic               ring_done;
  logic               cloud_done;

  modport source (output valid, point_x, point_y, point_number, ring_done, cloud_done,
                  input ready);
  modport sink (input valid, point_x, point_y, point_number, ring_done, cloud_done,
                output ready);
endinterface

FILE: design/oepr_front.sv
// Front end: takes a pose item and derives heading cosine and sine in Q1.14.
// Uses oepr_pkg and oepr_pose_if; iterative square root and division.
module oepr_front (
  input  logic            clk,
  input  logic            rst,
  oepr_pose_if.sink       pose,
  output oepr_pkg::head_t head,
  output logic            head_valid,
  input  logic            head_ready
);
  import oepr_pkg::*;

  typedef enum logic [2:0] {IDLE, PREP, SQ, ROOT, DIV, PUSH} state_t;

  state_t state;
  pose_t  hold;
  logic   hold_valid;

  logic signed [31:0] cur_px, cur_py;
  logic               cur_final;
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_wz, p_xy, p_xz, p_wy;
  logic [30:0]        an, ad;
  logic               num_neg, den_neg, degen;
  logic [63:0]        n, r, bitv;
  logic [33:0]        rem_c, rem_s;
  logic [14:0]        lo_c, lo_s, q_c, q_s;
  logic [1:0]         dcnt;

  logic signed [35:0] d36, num, den, g;
  logic [35:0]        abs_num, abs_den, abs_g, sh_num, sh_den;
  logic [63:0]        tn, tr, tb;
  logic [45:0]        nc, ns;
  logic [33:0]        trc, trs, t;
  logic [14:0]        tlc, tls, tqc, tqs;
  logic [15:0]        mc, ms;

  function automatic logic [15:0] clamp_q(logic [14:0] q);
    logic [15:0] v;
    v = {1'b0, q};
    if (v > 16'(ONE_Q14)) v = 16'(ONE_Q14);
    return v;
  endfunction

  assign pose.ready = !hold_valid;

  always_comb begin
    d36 = 36'(p_ww) + 36'(p_xx) + 36'(p_yy) + 36'(p_zz);
    num = (36'(p_wz) + 36'(p_xy)) <<< 1;
    den = d36 - ((36'(p_yy) + 36'(p_zz)) <<< 1);
    g   = (36'(p_xz) - 36'(p_wy)) <<< 1;
    abs_num = num[35] ? 36'(-num) : 36'(num);
    abs_den = den[35] ? 36'(-den) : 36'(den);
    abs_g   = g[35] ? 36'(-g) : 36'(g);
    if ((|abs_num[35:31]) || (|abs_den[35:31])) begin
      sh_num = abs_num >> 2;
      sh_den = abs_den >> 2;
    end else begin
      sh_num = abs_num;
      sh_den = abs_den;
    end
  end

  always_comb begin
    tn = n;
    tr = r;
    tb = bitv;
    for (int i = 0; i < 4; i++) begin
      if (tn >= tr + tb) begin
        tn = tn - (tr + tb);
        tr = (tr >> 1) + tb;
      end else begin
        tr = tr >> 1;
      end
      tb = tb >> 2;
    end
    nc = {1'b0, ad, 14'b0} + {15'b0, tr[31:1]};
    ns = {1'b0, an, 14'b0} + {15'b0, tr[31:1]};
  end

  always_comb begin
    trc = rem_c;
    trs = rem_s;
    tlc = lo_c;
    tls = lo_s;
    tqc = q_c;
    tqs = q_s;
    t   = '0;
    for (int i = 0; i < 5; i++) begin
      t = {trc[32:0], tlc[14]};
      tlc = tlc << 1;
      if (t >= {2'b0, r[31:0]}) begin
        trc = t - {2'b0, r[31:0]};
        tqc = {tqc[13:0], 1'b1};
      end else begin
        trc = t;
        tqc = {tqc[13:0], 1'b0};
      end
      t = {trs[32:0], tls[14]};
      tls = tls << 1;
      if (t >= {2'b0, r[31:0]}) begin
        trs = t - {2'b0, r[31:0]};
        tqs = {tqs[13:0], 1'b1};
      end else begin
        trs = t;
        tqs = {tqs[13:0], 1'b0};
      end
    end
  end

  always_comb begin
    mc = clamp_q(q_c);
    ms = clamp_q(q_s);
    head.px = cur_px;
    head.py = cur_py;
    head.final_p = cur_final;
    if (degen) begin
      head.c = 16'(ONE_Q14);
      head.s = '0;
    end else begin
      head.c = den_neg ? $signed(-mc) : $signed(mc);
      head.s = num_neg ? $signed(-ms) : $signed(ms);
    end
  end

  assign head_valid = (state == PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      hold_valid <= 1'b0;
    end else begin
      if (pose.valid && pose.ready) begin
        hold <= '{pose.person_x, pose.person_y, pose.quat_x, pose.quat_y,
                  pose.quat_z, pose.quat_w, pose.final_person};
        hold_valid <= 1'b1;
      end
      case (state)
        IDLE: begin
          if (hold_valid) begin
            p_ww <= hold.qw * hold.qw;
            p_xx <= hold.qx * hold.qx;
            p_yy <= hold.qy * hold.qy;
            p_zz <= hold.qz * hold.qz;
            p_wz <= hold.qw * hold.qz;
            p_xy <= hold.qx * hold.qy;
            p_xz <= hold.qx * hold.qz;
            p_wy <= hold.qw * hold.qy;
            cur_px <= hold.px;
            cur_py <= hold.py;
            cur_final <= hold.final_p;
            hold_valid <= 1'b0;
            state <= PREP;
          end
        end
        PREP: begin
          an <= sh_num[30:0];
          ad <= sh_den[30:0];
          num_neg <= num[35];
          den_neg <= den[35];
          degen <= ($signed({1'b0, abs_g}) >= $signed({d36[35], d36}));
          state <= SQ;
        end
        SQ: begin
          n <= 64'(an) * 64'(an) + 64'(ad) * 64'(ad);
          r <= '0;
          bitv <= 64'd1 << 62;
          state <= ROOT;
        end
        ROOT: begin
          n <= tn;
          r <= tr;
          bitv <= tb;
          if (tb == '0) begin
            rem_c <= {3'b0, nc[45:15]};
            lo_c <= nc[14:0];
            rem_s <= {3'b0, ns[45:15]};
            lo_s <= ns[14:0];
            q_c <= '0;
            q_s <= '0;
            dcnt <= '0;
            if (tr == '0) degen <= 1'b1;
            state <= DIV;
          end
        end
        DIV: begin
          rem_c <= trc;
          rem_s <= trs;
          lo_c <= tlc;
          lo_s <= tls;
          q_c <= tqc;
          q_s <= tqs;
          dcnt <= dcnt + 2'd1;
          if (dcnt == 2'd2) state <= PUSH;
        end
        PUSH: begin
          if (head_ready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: design/oepr_queue.sv
// Short queue of heading items between front and back end.
// Uses oepr_pkg.
module oepr_queue (
  input  logic            clk,
  input  logic            rst,
  input  oepr_pkg::head_t wr_data,
  input  logic            wr_valid,
  output logic            wr_ready,
  output oepr_pkg::head_t rd_data,
  output logic            rd_valid,
  input  logic            rd_ready
);
  import oepr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  head_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             push, pop;

  assign wr_ready = (count != (PTR_W + 1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

endmodule

FILE: design/oepr_back.sv
// Back end: walks the ring for each heading item and emits saturated points.
// Uses oepr_pkg and oepr_point_if; three-stage multiply and sum pipeline.
module oepr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  oepr_pkg::head_t           head,
  input  logic                      head_valid,
  output logic                      head_ready,
  input  logic [oepr_pkg::REG_W-1:0] along,
  input  logic [oepr_pkg::REG_W-1:0] across,
  input  logic [oepr_pkg::REG_W-1:0] offset,
  oepr_point_if.source              point
);
  import oepr_pkg::*;

  logic             adv, issue, last_pt;
  logic [PNT_W-1:0] j;
  logic signed [15:0] rc, rs;

  logic               a_v, b_v;
  logic signed [34:0] a_ar, a_br, a_co, a_so;
  logic signed [31:0] a_px, a_py, b_px, b_py;
  logic signed [15:0] a_c, a_s;
  logic [PNT_W-1:0]   a_j, b_j;
  logic               a_last, a_cloud, b_last, b_cloud;
  logic signed [50:0] b_arc, b_brs, b_ars, b_brc;
  logic signed [34:0] b_co, b_so;
  logic signed [63:0] sx, sy;

  function automatic logic signed [31:0] round_sat(logic signed [63:0] v);
    logic signed [63:0] q;
    q = (v + 64'sd134217728) >>> 28;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  assign adv        = !point.valid || point.ready;
  assign issue      = adv && head_valid;
  assign last_pt    = (j == PNT_W'(RING_POINTS - 1));
  assign head_ready = issue && last_pt;
  assign rc         = $signed(RING_TAB[j][31:16]);
  assign rs         = $signed(RING_TAB[j][15:0]);

  assign sx = (64'(b_px) <<< 28) + (64'(b_co) <<< 14) + 64'(b_arc) - 64'(b_brs);
  assign sy = (64'(b_py) <<< 28) + (64'(b_so) <<< 14) + 64'(b_ars) + 64'(b_brc);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ar <= $signed({1'b0, along}) * rc;
      a_br <= $signed({1'b0, across}) * rs;
      a_co <= $signed({1'b0, offset}) * head.c;
      a_so <= $signed({1'b0, offset}) * head.s;
      a_px <= head.px;
      a_py <= head.py;
      a_c <= head.c;
      a_s <= head.s;
      a_j <= j;
      a_last <= last_pt;
      a_cloud <= last_pt && head.final_p;
      b_arc <= a_ar * a_c;
      b_brs <= a_br * a_s;
      b_ars <= a_ar * a_s;
      b_brc <= a_br * a_c;
      b_co <= a_co;
      b_so <= a_so;
      b_px <= a_px;
      b_py <= a_py;
      b_j <= a_j;
      b_last <= a_last;
      b_cloud <= a_cloud;
      point.point_x <= round_sat(sx);
      point.point_y <= round_sat(sy);
      point.point_number <= 6'(b_j);
      point.ring_done <= b_last;
      point.cloud_done <= b_cloud;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
      a_v <= 1'b0;
      b_v <= 1'b0;
      point.valid <= 1'b0;
    end else if (adv) begin
      a_v <= issue;
      b_v <= a_v;
      point.valid <= b_v;
      if (issue) j <= last_pt ? '0 : j + 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_number_range: assert property (@(posedge clk) disable iff (rst)
    point.valid |-> (point.point_number < 6'(RING_POINTS)))
    else $error("point number beyond ring");
  a_ring_done: assert property (@(posedge clk) disable iff (rst)
    point.valid |-> (point.ring_done == (point.point_number == 6'(RING_POINTS - 1))))
    else $error("ring_done not on last point");
  a_cloud_done: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.cloud_done |-> point.ring_done)
    else $error("cloud_done without ring_done");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    head_ready |-> head_valid)
    else $error("queue popped while empty");
`endif

endmodule

FILE: design/oriented_ellipse_point_ring.sv
// Top level of the oriented ellipse point ring: configuration registers and wiring.
// Uses oepr_pkg, oepr_pose_if, oepr_point_if, oepr_front, oepr_queue, oepr_back.
//
// Usage:
//   pose  - valid/ready channel, one person pose (position, quaternion, final flag)
//           per item.
//   point - valid/ready channel, RING_POINTS ring points per pose, numbered from 0;
//           ring_done marks the last point, cloud_done the last point of a frame.
//   APB   - half_axis_along at 0x0, half_axis_across at 0x4, forward_offset at 0x8;
//           write only while the block is idle.
// Timing:
//   A pose is held in an input register, then the front works on it in order:
//   load, prepare, square, square root (four root bits a cycle), division
//   (five quotient bits a cycle) and a hand-off. The input register takes
//   the next pose while the front is busy; its loops limit the pose rate.
//   The back emits one point a cycle through a three-stage multiply/sum pipeline
//   while a heading is queued and the output is not stalled.
// Reset: synchronous; clears all handshakes and restores the default ellipse.
// Stall: a held point freezes the back pipeline; the two-entry queue and the input
//   register let the front keep taking poses until both are full.
module oriented_ellipse_point_ring (
  input  logic        clk,
  input  logic        rst,
  oepr_pose_if.sink   pose,
  oepr_point_if.source point,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import oepr_pkg::*;

  logic [REG_W-1:0] along, across, offset;
  head_t            f_head, q_head;
  logic             f_valid, f_ready, q_valid, q_ready;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      along <= ALONG_RESET;
      across <= ACROSS_RESET;
      offset <= OFFSET_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_ALONG:  along <= pwdata[REG_W-1:0];
        REG_ACROSS: across <= pwdata[REG_W-1:0];
        REG_OFFSET: offset <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ALONG:  prdata = 32'(along);
      REG_ACROSS: prdata = 32'(across);
      REG_OFFSET: prdata = 32'(offset);
      default:    prdata = '0;
    endcase
  end

  oepr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pose       (pose),
    .head       (f_head),
    .head_valid (f_valid),
    .head_ready (f_ready)
  );

  oepr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (f_head),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (q_head),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  oepr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_valid),
    .head_ready (q_ready),
    .along      (along),
    .across     (across),
    .offset     (offset),
    .point      (point)
  );

endmodule

FILE: test/oepr_ring_checker.sv
`timescale 1ns / 100ps
// Checker for the oriented ellipse point ring: watches the pose and point channels and
// the register writes, predicts each ring point and compares. Depends on oepr_pkg.
module oepr_ring_checker
  import oepr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  oepr_pose_if        pose,
  oepr_point_if       point,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          failures,
  output int          points_pending
);

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [5:0]         number;
    logic               ring_end;
    logic               cloud_end;
  } ring_point_t;

  ring_point_t expected_points[$];
  logic [REG_W-1:0] along, across, offset;

  function automatic longint fshift(longint v, int sh);
    return (v < 0) ? -1 - ((-1 - v) >> sh) : v >> sh;
  endfunction

  function automatic longint clamp14(longint v);
    if (v > ONE_Q14) return ONE_Q14;
    if (v < -ONE_Q14) return -ONE_Q14;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic find_heading(input longint qx, qy, qz, qw, output longint c, s);
    longint d, num, den, g;
    longint unsigned an, ad, r;
    d = qw * qw + qx * qx + qy * qy + qz * qz;
    num = 2 * (qw * qz + qx * qy);
    den = d - 2 * (qy * qy + qz * qz);
    g = 2 * (qx * qz - qw * qy);
    c = ONE_Q14;
    s = 0;
    if (((g < 0) ? -g : g) >= d) return;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    if (an >= (64'd1 << 31) || ad >= (64'd1 << 31)) begin
      an = an >> 2;
      ad = ad >> 2;
    end
    r = int_sqrt(an * an + ad * ad);
    if (r == 0) return;
    c = clamp14((ad * ONE_Q14 + r / 2) / r);
    s = clamp14((an * ONE_Q14 + r / 2) / r);
    if (den < 0) c = -c;
    if (num < 0) s = -s;
  endtask

  task automatic ring_angle(input int k, output longint rc, rs);
    longint atans [CORDIC_STEPS];
    longint m, th, x, y, nx;
    logic flip;
    atans = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
              4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
              16384, 8192};
    m = (2 * k <= RING_POINTS) ? k : k - RING_POINTS;
    th = (((m < 0) ? -m : m) * Q28_TWO_PI + RING_POINTS / 2) / RING_POINTS;
    if (m < 0) th = -th;
    flip = 1'b0;
    if (th > Q28_HALF_PI) begin
      th = th - Q28_PI;
      flip = 1'b1;
    end else if (th < -Q28_HALF_PI) begin
      th = th + Q28_PI;
      flip = 1'b1;
    end
    x = CORDIC_GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (th >= 0) begin
        nx = x - fshift(y, i);
        y = y + fshift(x, i);
        th = th - atans[i];
      end else begin
        nx = x + fshift(y, i);
        y = y - fshift(x, i);
        th = th + atans[i];
      end
      x = nx;
    end
    rc = clamp14(fshift(x + 32768, 16));
    rs = clamp14(fshift(y + 32768, 16));
    if (flip) begin
      rc = -rc;
      rs = -rs;
    end
  endtask

  function automatic logic [31:0] round_q16(longint v);
    longint r;
    r = fshift(v + (64'sd1 <<< 27), 28);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  task automatic predict_ring();
    longint px, py, c, s, rc, rs, a, b, off, sx, sy;
    ring_point_t p;
    px = pose.person_x;
    py = pose.person_y;
    find_heading(pose.quat_x, pose.quat_y, pose.quat_z, pose.quat_w, c, s);
    a = along;
    b = across;
    off = offset;
    for (int j = 0; j < RING_POINTS; j++) begin
      ring_angle(j + 1, rc, rs);
      sx = px * (64'sd1 <<< 28) + c * off * ONE_Q14 + a * rc * c - b * rs * s;
      sy = py * (64'sd1 <<< 28) + s * off * ONE_Q14 + a * rc * s + b * rs * c;
      p.x = round_q16(sx);
      p.y = round_q16(sy);
      p.number = 6'(j);
      p.ring_end = (j == RING_POINTS - 1);
      p.cloud_end = p.ring_end & pose.final_person;
      expected_points = {expected_points, p};
    end
  endtask

  task automatic check_point();
    ring_point_t e;
    if (expected_points.size() == 0) begin
      $display("%0t: unexpected point x=%h y=%h", $time, point.point_x, point.point_y);
      failures++;
      return;
    end
    e = expected_points.pop_front();
    if (point.point_x !== e.x || point.point_y !== e.y || point.point_number !== e.number
        || point.ring_done !== e.ring_end || point.cloud_done !== e.cloud_end) begin
      $display("%0t: expected x=%h y=%h n=%0d r=%b c=%b, got x=%h y=%h n=%0d r=%b c=%b",
               $time, e.x, e.y, e.number, e.ring_end, e.cloud_end, point.point_x,
               point.point_y, point.point_number, point.ring_done, point.cloud_done);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      along <= ALONG_RESET;
      across <= ACROSS_RESET;
      offset <= OFFSET_RESET;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ALONG: along <= pwdata[REG_W-1:0];
          REG_ACROSS: across <= pwdata[REG_W-1:0];
          REG_OFFSET: offset <= pwdata[REG_W-1:0];
          default: ;
        endcase
      end
      if (pose.valid && pose.ready) predict_ring();
      if (point.valid && point.ready) check_point();
    end
  end

  initial failures = 0;
  assign points_pending = expected_points.size();

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the oriented ellipse point ring: poses, register writes and
// random idling. Depends on oepr_pkg, both channel interfaces and oepr_ring_checker.
module testbench;
  import oepr_pkg::*;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  int failures, points_pending;
  int send_idle_pct = 0, take_idle_pct = 0;
  logic hold_off = 0;

  oepr_pose_if pose ();
  oepr_point_if point ();

  oriented_ellipse_point_ring uut (.clk, .rst, .pose(pose.sink), .point(point.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready);

  oepr_ring_checker ring_check (.clk, .rst, .pose, .point, .psel, .penable, .pwrite,
    .paddr, .pwdata, .pready, .failures, .points_pending);

  always #5 clk = ~clk;

  initial begin
    pose.valid = 0;
    pose.person_x = 0;
    pose.person_y = 0;
    pose.quat_x = 0;
    pose.quat_y = 0;
    pose.quat_z = 0;
    pose.quat_w = 0;
    pose.final_person = 0;
    point.ready = 0;
  end

  always @(negedge clk)
    point.ready <= !rst && !hold_off && ($urandom_range(99) >= take_idle_pct);

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(negedge clk);
  endtask

  task automatic send_pose(input logic [31:0] x, y, input logic [15:0] qx, qy, qz, qw,
                           input logic fin);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    pose.valid <= 1;
    pose.person_x <= x;
    pose.person_y <= y;
    pose.quat_x <= qx;
    pose.quat_y <= qy;
    pose.quat_z <= qz;
    pose.quat_w <= qw;
    pose.final_person <= fin;
    do @(posedge clk); while (!pose.ready);
    @(negedge clk);
    pose.valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_q14();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  task automatic random_pose();
    logic [31:0] x, y;
    case ($urandom_range(3))
      0: begin
        x = $urandom;
        y = $urandom;
      end
      default: begin
        x = $signed($urandom_range(2000000)) - 1000000;
        y = $signed($urandom_range(2000000)) - 1000000;
      end
    endcase
    if ($urandom_range(3) == 0)
      send_pose(x, y, rand_q14(), rand_q14(), rand_q14(), rand_q14(),
                1'($urandom_range(1)));
    else
      send_pose(x, y, 16'($signed($urandom_range(2000)) - 1000),
                16'($signed($urandom_range(2000)) - 1000), rand_q14(), rand_q14(),
                1'($urandom_range(1)));
  endtask

  task automatic drain();
    while (points_pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send_pose(0, 0, 0, 0, 0, 16384, 0);
    send_pose(32'h7fffffff, 32'h80000000, 0, 0, 16384, 0, 1);
    send_pose(32'h80000000, 32'h7fffffff, 0, 0, 16'hc000, 0, 0);
    send_pose(0, 0, 0, 0, 0, 0, 1);
    send_pose(100, -100, 0, 11585, 0, 11585, 0);
    send_pose(0, 0, 16384, 16384, 16384, 16384, 1);
    send_pose(0, 0, 16'hc000, 16'hc000, 16'hc000, 16'hc000, 0);
    send_pose(32'hffffffff, 1, 0, 0, 11585, 16'hd2bf, 1);
    send_pose(0, 0, 0, 0, 1, 0, 0);
    send_pose(0, 0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1);
    send_pose(0, 0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0);
    drain();
    write_reg(REG_ALONG, 32'h3ffff);
    write_reg(REG_ACROSS, 32'h3ffff);
    write_reg(REG_OFFSET, 32'h3ffff);
    send_pose(32'h7fff0000, 32'h80010000, 0, 0, 5000, 15000, 1);
    send_pose(32'h80010000, 32'h7fff0000, 0, 0, 16'hc000, 1, 1);
    drain();
    write_reg(REG_ALONG, 0);
    write_reg(REG_ACROSS, 0);
    write_reg(REG_OFFSET, 0);
    send_pose(12345, -54321, 0, 0, 3000, 16000, 1);
    drain();
    hold_off <= 1;
    fork
      begin
        repeat (200) @(negedge clk);
        hold_off <= 0;
      end
      repeat (6) random_pose();
    join
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 47 : 0;
      take_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 20 : 0;
      write_reg(REG_ALONG, $urandom_range(262143));
      write_reg(REG_ACROSS, $urandom_range(60000));
      write_reg(REG_OFFSET, $urandom_range(262143));
      repeat (85) random_pose();
      drain();
    end
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
